// ----- rtl/core/rtced_pkg.sv -----
// Shared types and constants for the clock-setting digit editor.
package rtced_pkg;

   // Stream word widths.
   localparam int unsigned ReqDataWidth = 56;
   localparam int unsigned RspDataWidth = 56;
   localparam int unsigned RspUserWidth = 2;

   // Key codes carried in the request word.
   typedef enum logic [2:0] {
      KEY_NEXT      = 3'd0,
      KEY_PREV      = 3'd1,
      KEY_UP        = 3'd2,
      KEY_STEP_DOWN = 3'd3,
      KEY_COMMIT    = 3'd4,
      KEY_NONE      = 3'd5
   } key_type;

   // Cursor positions on the display.
   localparam logic [3:0] POS_FIRST      = 4'd0;
   localparam logic [3:0] POS_YEAR_TENS  = 4'd2;
   localparam logic [3:0] POS_YEAR_ONES  = 4'd3;
   localparam logic [3:0] POS_MONTH_TENS = 4'd4;
   localparam logic [3:0] POS_MONTH_ONES = 4'd5;
   localparam logic [3:0] POS_DAY_TENS   = 4'd6;
   localparam logic [3:0] POS_DAY_ONES   = 4'd7;
   localparam logic [3:0] POS_HOUR_TENS  = 4'd8;
   localparam logic [3:0] POS_HOUR_ONES  = 4'd9;
   localparam logic [3:0] POS_MIN_TENS   = 4'd10;
   localparam logic [3:0] POS_MIN_ONES   = 4'd11;
   localparam logic [3:0] POS_WEEKDAY    = 4'd12;
   localparam logic [3:0] POS_LAST       = POS_WEEKDAY;

   // Wrap limits of the editable digits.
   localparam logic [3:0] LIMIT_ONES       = 4'd9;
   localparam logic [3:0] LIMIT_MIN_TENS   = 4'd6;
   localparam logic [3:0] LIMIT_HOUR_TENS  = 4'd6;
   localparam logic [3:0] LIMIT_DAY_TENS   = 4'd3;
   localparam logic [3:0] LIMIT_MONTH_TENS = 4'd1;
   localparam logic [3:0] LIMIT_YEAR_TENS  = 4'd9;

   // Upper bounds applied after an edit, with their digits.
   localparam int unsigned MinuteMax = 60;
   localparam int unsigned HourMax   = 60;
   localparam int unsigned MonthMax  = 12;
   localparam int unsigned DayMax    = 31;
   localparam logic [7:0] MINUTE_MAX      = 8'(MinuteMax);
   localparam logic [3:0] MINUTE_MAX_TENS = 4'(MinuteMax / 10);
   localparam logic [3:0] MINUTE_MAX_ONES = 4'(MinuteMax % 10);
   localparam logic [7:0] HOUR_MAX        = 8'(HourMax);
   localparam logic [3:0] HOUR_MAX_TENS   = 4'(HourMax / 10);
   localparam logic [3:0] HOUR_MAX_ONES   = 4'(HourMax % 10);
   localparam logic [7:0] MONTH_MAX       = 8'(MonthMax);
   localparam logic [3:0] MONTH_MAX_TENS  = 4'(MonthMax / 10);
   localparam logic [3:0] MONTH_MAX_ONES  = 4'(MonthMax % 10);
   localparam logic [7:0] DAY_MAX         = 8'(DayMax);
   localparam logic [3:0] DAY_MAX_TENS    = 4'(DayMax / 10);
   localparam logic [3:0] DAY_MAX_ONES    = 4'(DayMax % 10);

   // Time held as separate BCD digits.
   typedef struct packed {
      logic [2:0] weekday;
      logic [3:0] second_tens;
      logic [3:0] second_ones;
      logic [3:0] minute_tens;
      logic [3:0] minute_ones;
      logic [3:0] hour_tens;
      logic [3:0] hour_ones;
      logic [3:0] day_tens;
      logic [3:0] day_ones;
      logic [3:0] month_tens;
      logic [3:0] month_ones;
      logic [3:0] year_tens;
      logic [3:0] year_ones;
   } digits_type;

   // Editor state kept between words.
   typedef struct packed {
      logic [3:0] cursor;
      logic       enter_toggle;
      digits_type digits;
   } edit_state_type;

   // Request word fields.
   typedef struct packed {
      logic       kind;
      logic [2:0] key_code;
      logic [7:0] load_seconds;
      logic [7:0] load_minutes;
      logic [7:0] load_hours;
      logic [7:0] load_day;
      logic [7:0] load_month;
      logic [2:0] load_weekday;
      logic [7:0] load_year;
   } req_word_type;

   // Response word fields.
   typedef struct packed {
      logic       write_strobe;
      logic       stay_in_setup;
      logic [3:0] cursor_pos;
      logic [7:0] out_seconds;
      logic [7:0] out_minutes;
      logic [7:0] out_hours;
      logic [7:0] out_day;
      logic [7:0] out_month;
      logic [2:0] out_weekday;
      logic [7:0] out_year;
   } rsp_word_type;

endpackage

// ----- rtl/core/rtced_step.sv -----
// Combinational edit step: applies one word to the editor state and forms the response.
module rtced_step (
   input  rtced_pkg::req_word_type   req_word,
   input  rtced_pkg::edit_state_type state_cur,
   output rtced_pkg::edit_state_type state_nxt,
   output rtced_pkg::rsp_word_type   rsp_word
);
   import rtced_pkg::*;

   // Step a digit up, wrapping from its limit to zero.
   function automatic logic [3:0] dig_up(input logic [3:0] d, input logic [3:0] lim);
      return (d == lim) ? 4'd0 : d + 4'd1;
   endfunction

   // Step a digit down, wrapping from zero to its limit.
   function automatic logic [3:0] dig_down(input logic [3:0] d, input logic [3:0] lim);
      return (d == 4'd0) ? lim : d - 4'd1;
   endfunction

   // Replace a two-digit value above its bound by the bound.
   function automatic logic [7:0] clamp_pair(input logic [3:0] t, input logic [3:0] o,
                                             input logic [7:0] maxv,
                                             input logic [3:0] max_t,
                                             input logic [3:0] max_o);
      logic [7:0] value;
      value = ({4'd0, t} * 8'd10) + {4'd0, o};
      return (value > maxv) ? {max_t, max_o} : {t, o};
   endfunction

   digits_type d_edit;
   digits_type d_clamp;
   digits_type d_next;
   digits_type d_rsp;
   logic [3:0] cursor_next;
   logic       toggle_next;
   logic       clamp_en;
   logic       strobe;
   logic       stay;
   logic       is_enter;

   // Apply the load or the key press.
   always_comb begin
      d_edit      = state_cur.digits;
      cursor_next = state_cur.cursor;
      toggle_next = state_cur.enter_toggle;
      clamp_en    = 1'b0;
      strobe      = 1'b0;
      stay        = 1'b1;
      is_enter    = 1'b0;
      if (req_word.kind) begin
         d_edit.second_tens = req_word.load_seconds[7:4];
         d_edit.second_ones = req_word.load_seconds[3:0];
         d_edit.minute_tens = req_word.load_minutes[7:4];
         d_edit.minute_ones = req_word.load_minutes[3:0];
         d_edit.hour_tens   = req_word.load_hours[7:4];
         d_edit.hour_ones   = req_word.load_hours[3:0];
         d_edit.day_tens    = req_word.load_day[7:4];
         d_edit.day_ones    = req_word.load_day[3:0];
         d_edit.month_tens  = req_word.load_month[7:4];
         d_edit.month_ones  = req_word.load_month[3:0];
         d_edit.weekday     = req_word.load_weekday;
         d_edit.year_tens   = req_word.load_year[7:4];
         d_edit.year_ones   = req_word.load_year[3:0];
      end else begin
         clamp_en = 1'b1;
         case (key_type'(req_word.key_code))
            KEY_NEXT: begin
               cursor_next = (state_cur.cursor >= POS_LAST) ? POS_FIRST
                                                            : state_cur.cursor + 4'd1;
            end
            KEY_PREV: begin
               cursor_next = (state_cur.cursor == POS_FIRST) ? POS_LAST
                                                             : state_cur.cursor - 4'd1;
            end
            KEY_UP: begin
               case (state_cur.cursor)
                  POS_WEEKDAY:    d_edit.weekday     = state_cur.digits.weekday + 3'd1;
                  POS_MIN_ONES:   d_edit.minute_ones = dig_up(d_edit.minute_ones, LIMIT_ONES);
                  POS_MIN_TENS:   d_edit.minute_tens = dig_up(d_edit.minute_tens,
                                                              LIMIT_MIN_TENS);
                  POS_HOUR_ONES:  d_edit.hour_ones   = dig_up(d_edit.hour_ones, LIMIT_ONES);
                  POS_HOUR_TENS:  d_edit.hour_tens   = dig_up(d_edit.hour_tens,
                                                              LIMIT_HOUR_TENS);
                  POS_DAY_ONES:   d_edit.day_ones    = dig_up(d_edit.day_ones, LIMIT_ONES);
                  POS_DAY_TENS:   d_edit.day_tens    = dig_up(d_edit.day_tens, LIMIT_DAY_TENS);
                  POS_MONTH_ONES: d_edit.month_ones  = dig_up(d_edit.month_ones, LIMIT_ONES);
                  POS_MONTH_TENS: d_edit.month_tens  = dig_up(d_edit.month_tens,
                                                              LIMIT_MONTH_TENS);
                  POS_YEAR_ONES:  d_edit.year_ones   = dig_up(d_edit.year_ones, LIMIT_ONES);
                  POS_YEAR_TENS:  d_edit.year_tens   = dig_up(d_edit.year_tens,
                                                              LIMIT_YEAR_TENS);
                  default: ;
               endcase
            end
            KEY_STEP_DOWN: begin
               case (state_cur.cursor)
                  POS_WEEKDAY:    d_edit.weekday     = state_cur.digits.weekday - 3'd1;
                  POS_MIN_ONES:   d_edit.minute_ones = dig_down(d_edit.minute_ones, LIMIT_ONES);
                  POS_MIN_TENS:   d_edit.minute_tens = dig_down(d_edit.minute_tens,
                                                                LIMIT_MIN_TENS);
                  POS_HOUR_ONES:  d_edit.hour_ones   = dig_down(d_edit.hour_ones, LIMIT_ONES);
                  POS_HOUR_TENS:  d_edit.hour_tens   = dig_down(d_edit.hour_tens,
                                                                LIMIT_HOUR_TENS);
                  POS_DAY_ONES:   d_edit.day_ones    = dig_down(d_edit.day_ones, LIMIT_ONES);
                  POS_DAY_TENS:   d_edit.day_tens    = dig_down(d_edit.day_tens,
                                                                LIMIT_DAY_TENS);
                  POS_MONTH_ONES: d_edit.month_ones  = dig_down(d_edit.month_ones, LIMIT_ONES);
                  POS_MONTH_TENS: d_edit.month_tens  = dig_down(d_edit.month_tens,
                                                                LIMIT_MONTH_TENS);
                  POS_YEAR_ONES:  d_edit.year_ones   = dig_down(d_edit.year_ones, LIMIT_ONES);
                  POS_YEAR_TENS:  d_edit.year_tens   = dig_down(d_edit.year_tens,
                                                                LIMIT_YEAR_TENS);
                  default: ;
               endcase
            end
            KEY_COMMIT: begin
               // The clamp is skipped when the toggle falls back to zero.
               toggle_next = ~state_cur.enter_toggle;
               clamp_en    = toggle_next;
               stay        = toggle_next;
               strobe      = 1'b1;
               is_enter    = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Bound minutes, hours, month and day.
   always_comb begin
      d_clamp = d_edit;
      {d_clamp.minute_tens, d_clamp.minute_ones} =
         clamp_pair(d_edit.minute_tens, d_edit.minute_ones,
                    MINUTE_MAX, MINUTE_MAX_TENS, MINUTE_MAX_ONES);
      {d_clamp.hour_tens, d_clamp.hour_ones} =
         clamp_pair(d_edit.hour_tens, d_edit.hour_ones, HOUR_MAX, HOUR_MAX_TENS, HOUR_MAX_ONES);
      {d_clamp.month_tens, d_clamp.month_ones} =
         clamp_pair(d_edit.month_tens, d_edit.month_ones,
                    MONTH_MAX, MONTH_MAX_TENS, MONTH_MAX_ONES);
      {d_clamp.day_tens, d_clamp.day_ones} =
         clamp_pair(d_edit.day_tens, d_edit.day_ones, DAY_MAX, DAY_MAX_TENS, DAY_MAX_ONES);
   end

   // Enter reports the digits as they stood before the clamp.
   assign d_next = clamp_en ? d_clamp : d_edit;
   assign d_rsp  = is_enter ? d_edit : d_next;

   assign state_nxt.cursor       = cursor_next;
   assign state_nxt.enter_toggle = toggle_next;
   assign state_nxt.digits       = d_next;

   // Pack the response word.
   assign rsp_word.write_strobe  = strobe;
   assign rsp_word.stay_in_setup = stay;
   assign rsp_word.cursor_pos    = cursor_next;
   assign rsp_word.out_seconds   = {d_rsp.second_tens, d_rsp.second_ones};
   assign rsp_word.out_minutes   = {d_rsp.minute_tens, d_rsp.minute_ones};
   assign rsp_word.out_hours     = {d_rsp.hour_tens, d_rsp.hour_ones};
   assign rsp_word.out_day       = {d_rsp.day_tens, d_rsp.day_ones};
   assign rsp_word.out_month     = {d_rsp.month_tens, d_rsp.month_ones};
   assign rsp_word.out_weekday   = d_rsp.weekday;
   assign rsp_word.out_year      = {d_rsp.year_tens, d_rsp.year_ones};

endmodule

// ----- rtl/core/rtc_time_set_digit_editor.sv -----
// Top level of the clock-setting digit editor with request and response registers.
//
// Usage: each request word is either a key press (tuser = 0) or a load of the
// time fields read from the clock (tuser = 1). Every accepted word gives
// exactly one response word carrying the cursor position, the packed BCD time
// and two flags: a write strobe raised by enter and the stay-in-setup flag.
// A word is registered on acceptance, passes through the edit logic and lands in
// the response register. One word per cycle is sustained while rsp_tready stays
// high; the edit logic between the two registers is the only path that updates
// the editor state.
// Reset clears the cursor, the enter toggle, all digits and both valid flags.
// When the receiver holds rsp_tready low, the response register holds its word,
// one more word may wait in the request register, and req_tready then drops
// until the response is taken.
module rtc_time_set_digit_editor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // From bit 0: key_code[2:0], load_seconds[10:3], load_minutes[18:11],
   // load_hours[26:19], load_day[34:27], load_month[42:35],
   // load_weekday[45:43], load_year[53:46], zero fill.
   input  logic [rtced_pkg::ReqDataWidth-1:0]     req_tdata,
   // Bit 0: kind.
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // From bit 0: cursor_pos[3:0], out_seconds[11:4], out_minutes[19:12],
   // out_hours[27:20], out_day[35:28], out_month[43:36], out_weekday[46:44],
   // out_year[54:47], zero fill.
   output logic [rtced_pkg::RspDataWidth-1:0]     rsp_tdata,
   // From bit 0: write_strobe, stay_in_setup.
   output logic [rtced_pkg::RspUserWidth-1:0]     rsp_tuser
);
   import rtced_pkg::*;

   req_word_type   req_word_in;
   req_word_type   req_word_ff;
   logic           req_valid_ff;
   rsp_word_type   rsp_word_in;
   rsp_word_type   rsp_word_ff;
   logic           rsp_valid_ff;
   edit_state_type state_in;
   edit_state_type state_ff;
   logic           advance;

   // Unpack the request word.
   assign req_word_in.kind         = req_tuser;
   assign req_word_in.key_code     = req_tdata[2:0];
   assign req_word_in.load_seconds = req_tdata[10:3];
   assign req_word_in.load_minutes = req_tdata[18:11];
   assign req_word_in.load_hours   = req_tdata[26:19];
   assign req_word_in.load_day     = req_tdata[34:27];
   assign req_word_in.load_month   = req_tdata[42:35];
   assign req_word_in.load_weekday = req_tdata[45:43];
   assign req_word_in.load_year    = req_tdata[53:46];

   // A registered word moves on when the response register is free or being drained.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   rtced_step u_step (
      .req_word  (req_word_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp_word  (rsp_word_in)
   );

   // Control state and editor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_word_ff <= req_word_in;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Pack the response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_word_ff.stay_in_setup, rsp_word_ff.write_strobe};
   assign rsp_tdata  = {1'b0,
                        rsp_word_ff.out_year,
                        rsp_word_ff.out_weekday,
                        rsp_word_ff.out_month,
                        rsp_word_ff.out_day,
                        rsp_word_ff.out_hours,
                        rsp_word_ff.out_minutes,
                        rsp_word_ff.out_seconds,
                        rsp_word_ff.cursor_pos};

endmodule
